// ===== src/vnf_pkg.sv =====
// ----------------------------------------------------------------------------
// vnf_pkg
// shared types, constants and functions of the fractal value noise block
// ----------------------------------------------------------------------------
package vnf_pkg;

  localparam int unsigned CoordWidth = 24;
  localparam int unsigned NoiseWidth = 31;
  localparam int unsigned FracWidth  = 16;
  localparam int unsigned WeightWidth = 17;

  localparam logic [31:0] HashMulA = 32'd60493;
  localparam logic [31:0] HashAddA = 32'd19990303;
  localparam logic [31:0] HashAddB = 32'd1376312589;
  localparam logic [31:0] HashMask = 32'h7fff_ffff;
  localparam logic [31:0] OneQ30   = 32'h4000_0000;

  localparam logic [63:0] RomOneQ30 = 64'd1073741824;
  localparam logic [63:0] RomPiQ30  = 64'd3373259426;

  typedef logic [31:0]            hash_word_t;
  typedef logic signed [31:0]     corner_t;
  typedef logic [WeightWidth-1:0] weight_t;

  // blend weight entry k of a table with 2^bits entries, evaluated at elaboration
  function automatic weight_t weight_entry(input int unsigned k, input int unsigned bits);
    logic [63:0] t;
    logic [63:0] t2;
    logic [63:0] acc;
    logic [63:0] s;
    logic [63:0] e;
    t   = (64'(k) * RomPiQ30) >> (bits + 1);
    t2  = (t * t) >> 30;
    acc = RomOneQ30;
    acc = RomOneQ30 - ((t2 * acc) >> 30) / 64'd110;
    acc = RomOneQ30 - ((t2 * acc) >> 30) / 64'd72;
    acc = RomOneQ30 - ((t2 * acc) >> 30) / 64'd42;
    acc = RomOneQ30 - ((t2 * acc) >> 30) / 64'd20;
    acc = RomOneQ30 - ((t2 * acc) >> 30) / 64'd6;
    s   = (t * acc) >> 30;
    e   = (s * s + (64'd1 << 43)) >> 44;
    return e[WeightWidth-1:0];
  endfunction

  // a + floor((b - a) * w / 2^16)
  function automatic corner_t blend(input corner_t a, input corner_t b, input weight_t w);
    logic signed [32:0] d;
    logic signed [50:0] p;
    logic signed [50:0] r;
    d = 33'(b) - 33'(a);
    p = 51'(d) * 51'($signed({1'b0, w}));
    r = 51'(a) + (p >>> FracWidth);
    return r[31:0];
  endfunction

endpackage

// ===== src/vnf_if.sv =====
// ----------------------------------------------------------------------------
// vnf_coord_if / vnf_noise_if
// valid/ready channels carrying coordinate words and noise words
// ----------------------------------------------------------------------------
interface vnf_coord_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [vnf_pkg::CoordWidth-1:0]  x_coord;
  logic signed [vnf_pkg::CoordWidth-1:0]  y_coord;

  modport source (output valid, output x_coord, output y_coord, input ready);
  modport sink   (input valid, input x_coord, input y_coord, output ready);
endinterface

interface vnf_noise_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [vnf_pkg::NoiseWidth-1:0]  noise_value;

  modport source (output valid, output noise_value, input ready);
  modport sink   (input valid, input noise_value, output ready);
endinterface

// ===== src/vnf_weight_rom.sv =====
// ----------------------------------------------------------------------------
// vnf_weight_rom
// constant cosine blend weight table, sin^2 shaped, Q16
// ----------------------------------------------------------------------------
module vnf_weight_rom #(
  parameter int unsigned WEIGHT_TABLE_BITS = 10
) (
  input  logic [WEIGHT_TABLE_BITS-1:0] idx_i,
  output vnf_pkg::weight_t             weight_o
);

  localparam int unsigned Depth = 2 ** WEIGHT_TABLE_BITS;

  vnf_pkg::weight_t rom [Depth];

  for (genvar k = 0; k < Depth; k++) begin : g_entry
    assign rom[k] = vnf_pkg::weight_entry(k, WEIGHT_TABLE_BITS);
  end

  assign weight_o = rom[idx_i];

endmodule

// ===== src/vnf_hash.sv =====
// ----------------------------------------------------------------------------
// vnf_hash
// three stage integer hash of a mixed lattice word, gives corner value q30
// ----------------------------------------------------------------------------
module vnf_hash (
  input  logic                clk_i,
  input  logic [2:0]          en_i,
  input  vnf_pkg::hash_word_t n_i,
  output vnf_pkg::corner_t    value_o
);

  vnf_pkg::hash_word_t n2_q, sq_q, n3_q, nn_q;
  vnf_pkg::hash_word_t sq_d, nn_d, h_d;
  vnf_pkg::corner_t    value_q, value_d;

  always_comb begin
    sq_d    = n_i * n_i;
    nn_d    = sq_q * vnf_pkg::HashMulA + vnf_pkg::HashAddA;
    h_d     = (n3_q * nn_q + vnf_pkg::HashAddB) & vnf_pkg::HashMask;
    value_d = $signed(vnf_pkg::OneQ30 - h_d);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      n2_q <= n_i;
      sq_q <= sq_d;
    end
    if (en_i[1]) begin
      n3_q <= n2_q;
      nn_q <= nn_d;
    end
    if (en_i[2]) begin
      value_q <= value_d;
    end
  end

  assign value_o = value_q;

endmodule

// ===== src/vnf_octave.sv =====
// ----------------------------------------------------------------------------
// vnf_octave
// one octave lane: lattice split, four corner hashes, two level blend
// ----------------------------------------------------------------------------
module vnf_octave #(
  parameter int unsigned LEVEL             = 0,
  parameter int unsigned WEIGHT_TABLE_BITS = 10
) (
  input  logic                                  clk_i,
  input  logic [5:0]                            en_i,
  input  logic signed [vnf_pkg::CoordWidth-1:0] x_i,
  input  logic signed [vnf_pkg::CoordWidth-1:0] y_i,
  output logic signed [vnf_pkg::NoiseWidth-1:0] term_o
);

  localparam int unsigned Ftop = vnf_pkg::FracWidth - 1;

  logic signed [31:0]  sx, sy;
  logic [31:0]         mx, my;
  logic [31:0]         x1, x2, y1, y2;
  logic [WEIGHT_TABLE_BITS-1:0] ix_w, iy_w;
  vnf_pkg::weight_t    wx_d, wy_d;
  vnf_pkg::hash_word_t n_d [4];

  vnf_pkg::hash_word_t n_q [4];
  vnf_pkg::weight_t    wx_q [4];
  vnf_pkg::weight_t    wy_q [5];
  vnf_pkg::corner_t    v [4];
  vnf_pkg::corner_t    top_q, bot_q, r_q;
  logic signed [31:0]  term_w;

  // mixes corner (a, b) into the first hash word
  function automatic vnf_pkg::hash_word_t mix(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] n;
    n = a + (b << 6) - (b << 3) + b;
    return (n << 13) ^ n;
  endfunction

  always_comb begin
    sx = 32'(x_i) <<< LEVEL;
    sy = 32'(y_i) <<< LEVEL;
    mx = sx[31] ? 32'(-sx) : 32'(sx);
    my = sy[31] ? 32'(-sy) : 32'(sy);
    x1 = sx[31] ? 32'(-(mx >> vnf_pkg::FracWidth)) : (mx >> vnf_pkg::FracWidth);
    y1 = sy[31] ? 32'(-(my >> vnf_pkg::FracWidth)) : (my >> vnf_pkg::FracWidth);
    // neighbour steps toward the sign, stays put at zero
    x2 = sx[31] ? x1 - 32'd1 : ((sx != 0) ? x1 + 32'd1 : x1);
    y2 = sy[31] ? y1 - 32'd1 : ((sy != 0) ? y1 + 32'd1 : y1);
    ix_w = mx[Ftop -: WEIGHT_TABLE_BITS];
    iy_w = my[Ftop -: WEIGHT_TABLE_BITS];
    n_d[0] = mix(x1, y1);
    n_d[1] = mix(x2, y1);
    n_d[2] = mix(x1, y2);
    n_d[3] = mix(x2, y2);
  end

  vnf_weight_rom #(.WEIGHT_TABLE_BITS(WEIGHT_TABLE_BITS)) u_rom_x (
    .idx_i(ix_w), .weight_o(wx_d)
  );
  vnf_weight_rom #(.WEIGHT_TABLE_BITS(WEIGHT_TABLE_BITS)) u_rom_y (
    .idx_i(iy_w), .weight_o(wy_d)
  );

  for (genvar c = 0; c < 4; c++) begin : g_corner
    vnf_hash u_hash (
      .clk_i  (clk_i),
      .en_i   (en_i[3:1]),
      .n_i    (n_q[c]),
      .value_o(v[c])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      n_q   <= n_d;
      wx_q[0] <= wx_d;
      wy_q[0] <= wy_d;
    end
    for (int s = 1; s < 4; s++) begin
      if (en_i[s]) begin
        wx_q[s] <= wx_q[s-1];
        wy_q[s] <= wy_q[s-1];
      end
    end
    if (en_i[4]) begin
      top_q   <= vnf_pkg::blend(v[0], v[1], wx_q[3]);
      bot_q   <= vnf_pkg::blend(v[2], v[3], wx_q[3]);
      wy_q[4] <= wy_q[3];
    end
    if (en_i[5]) begin
      r_q <= vnf_pkg::blend(top_q, bot_q, wy_q[4]);
    end
  end

  assign term_w = r_q >>> (LEVEL + 2);
  assign term_o = term_w[vnf_pkg::NoiseWidth-1:0];

endmodule

// ===== src/fractal_value_noise_2d_top.sv =====
// throughput: one word per cycle unless the output stalls, every octave runs in its own parallel lane
// the hash's three chained 32-bit multiplies set the stage count
// per-stage valid bits; a bubble is filled even while the output stalls
// reset clears all valid bits at once, no warm-up pass is needed
// ----------------------------------------------------------------------------
// fractal_value_noise_2d_top
// fractal 2d value noise, sum of octaves with cosine blended lattice values
// ----------------------------------------------------------------------------
module fractal_value_noise_2d_top #(
  parameter int unsigned OCTAVE_COUNT      = 8,
  parameter int unsigned WEIGHT_TABLE_BITS = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  vnf_coord_if.sink          in_i,
  vnf_noise_if.source        out_o
);

  // stages: 1 split/mix/rom, 2..4 hash, 5 x blend, 6 y blend, 7 octave sum
  localparam int unsigned Stages = 7;

  logic [Stages:1]   valid_q;
  logic [Stages+1:1] en;
  logic signed [vnf_pkg::NoiseWidth-1:0] term [OCTAVE_COUNT];
  logic signed [vnf_pkg::NoiseWidth-1:0] sum_d, sum_q;

  // a stage may load when it is empty or its content moves on
  always_comb begin
    en[Stages+1] = out_o.ready;
    for (int s = Stages; s >= 1; s--) begin
      en[s] = !valid_q[s] || en[s+1];
    end
  end

  assign in_i.ready = en[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[1]) begin
        valid_q[1] <= in_i.valid;
      end
      for (int s = 2; s <= Stages; s++) begin
        if (en[s]) begin
          valid_q[s] <= valid_q[s-1];
        end
      end
    end
  end

  // octave lanes, octave i sees the coordinate scaled by 2^i
  for (genvar o = 0; o < OCTAVE_COUNT; o++) begin : g_oct
    vnf_octave #(
      .LEVEL            (o),
      .WEIGHT_TABLE_BITS(WEIGHT_TABLE_BITS)
    ) u_oct (
      .clk_i (clk_i),
      .en_i  (en[6:1]),
      .x_i   (in_i.x_coord),
      .y_i   (in_i.y_coord),
      .term_o(term[o])
    );
  end

  // exact sum of the terms, wraps at the output width
  always_comb begin
    sum_d = '0;
    for (int o = 0; o < OCTAVE_COUNT; o++) begin
      sum_d = sum_d + term[o];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[Stages]) begin
      sum_q <= sum_d;
    end
  end

  assign out_o.valid       = valid_q[Stages];
  assign out_o.noise_value = sum_q;

  // accepted word lands in stage one
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> valid_q[1])
    else $error("accepted word not captured");

  // a stalled stage keeps its word
  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[3] && !en[4] |=> valid_q[3])
    else $error("stalled word lost");

  // a waiting result keeps its value
  a_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[Stages] && !out_o.ready |=> valid_q[Stages] && $stable(sum_q))
    else $error("waiting result changed");

  // an empty last stage never blocks the pipe
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_q[Stages] |-> en[Stages])
    else $error("empty output stage stalls");

endmodule

// ===== sim/tb_fractal_value_noise_2d_top.sv =====
// ----------------------------------------------------------------------------
// tb_fractal_value_noise_2d_top
// self-checking bench for the fractal value noise block: coordinate words go
// in under random idling and back-pressure, each noise word is compared with
// a bit-exact software model of the octave sum kept in this file
// ----------------------------------------------------------------------------
module tb_fractal_value_noise_2d_top;

  localparam int unsigned Octaves     = 8;
  localparam int unsigned WeightBits  = 10;
  localparam int unsigned DrainCycles = 40;   // idle slack after the pipe has emptied, for strays

  logic clk_i;
  logic rst_ni;

  vnf_coord_if coord_if ();
  vnf_noise_if noise_if ();

  fractal_value_noise_2d_top #(
    .OCTAVE_COUNT      (Octaves),
    .WEIGHT_TABLE_BITS (WeightBits)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (coord_if.sink),
    .out_o  (noise_if.source)
  );

  // cosine blend weights, Q16, rebuilt here from the same series
  longint unsigned cos_weight [1 << WeightBits];

  // noise words still owed by the block, oldest first
  logic [vnf_pkg::NoiseWidth-1:0] pending_noise [$];

  int tx_idle_pct;     // chance of a gap before a coordinate word
  int rx_idle_pct;     // chance of ready low on a cycle
  int rx_hold_left;    // long receiver stall, counted down below
  int errors;

  // clock and time limit
  always #4 clk_i = ~clk_i;

  initial begin
    #4000000;
    $display("fractal_value_noise_2d_top test failed");
    $finish;
  end

  // ---------------------------------------------------------------- model

  // sine via Q30 taylor series, squared and rounded to Q16
  task automatic build_cos_weights();
    longint unsigned t, t2, acc, s;
    for (int k = 0; k < (1 << WeightBits); k++) begin
      t   = (longint'(k) * 64'd3373259426) >> (WeightBits + 1);
      t2  = (t * t) >> 30;
      acc = 64'd1073741824;
      acc = 64'd1073741824 - ((t2 * acc) >> 30) / 110;
      acc = 64'd1073741824 - ((t2 * acc) >> 30) / 72;
      acc = 64'd1073741824 - ((t2 * acc) >> 30) / 42;
      acc = 64'd1073741824 - ((t2 * acc) >> 30) / 20;
      acc = 64'd1073741824 - ((t2 * acc) >> 30) / 6;
      s   = (t * acc) >> 30;
      cos_weight[k] = (s * s + (64'd1 << 43)) >> 44;
    end
  endtask

  // lattice value 2^30 - h, all hash steps wrap at 32 bits
  function automatic longint lattice_height(longint ix, longint iy);
    bit [31:0] n, m;
    n = 32'(ix + iy * 57);
    n = (n << 13) ^ n;
    m = n * n;
    m = m * 32'd60493 + 32'd19990303;
    m = n * m + 32'd1376312589;
    m = m & 32'h7fff_ffff;
    return longint'(1073741824) - longint'(m);
  endfunction

  function automatic longint cos_mix(longint a, longint b, bit [15:0] frac);
    longint w;
    w = longint'(cos_weight[frac >> (16 - WeightBits)]);
    return a + (((b - a) * w) >>> 16);   // arithmetic shift is floor
  endfunction

  function automatic bit [vnf_pkg::NoiseWidth-1:0] fbm_noise(
    logic signed [vnf_pkg::CoordWidth-1:0] xc,
    logic signed [vnf_pkg::CoordWidth-1:0] yc);
    longint sx, sy, mx, my, x1, x2, y1, y2, top, bot, total;
    bit [15:0] fx, fy;
    total = 0;
    for (int i = 0; i < Octaves; i++) begin
      sx = longint'(xc) * (longint'(1) << i);
      sy = longint'(yc) * (longint'(1) << i);
      mx = (sx < 0) ? -sx : sx;
      my = (sy < 0) ? -sy : sy;
      // truncate toward zero, neighbor one step away from zero
      x1 = (sx < 0) ? -(mx >> 16) : (mx >> 16);
      y1 = (sy < 0) ? -(my >> 16) : (my >> 16);
      x2 = x1 + ((sx > 0) ? 1 : (sx < 0) ? -1 : 0);
      y2 = y1 + ((sy > 0) ? 1 : (sy < 0) ? -1 : 0);
      fx = mx[15:0];
      fy = my[15:0];
      top = cos_mix(lattice_height(x1, y1), lattice_height(x2, y1), fx);
      bot = cos_mix(lattice_height(x1, y2), lattice_height(x2, y2), fx);
      total += cos_mix(top, bot, fy) >>> (2 + i);
    end
    return total[vnf_pkg::NoiseWidth-1:0];
  endfunction

  // ------------------------------------------------------------ receiver

  // long stall has priority over random idling
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      noise_if.ready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      noise_if.ready <= 1'b0;
    end else begin
      noise_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rx_hold_left > 0) begin
      rx_hold_left <= rx_hold_left - 1;
    end
  end

  // compare every noise word with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && noise_if.valid && noise_if.ready) begin
      if (pending_noise.size() == 0) begin
        $display("%0t: unexpected noise word, expected none, actual %h",
                 $time, noise_if.noise_value);
        errors++;
      end else begin
        if (noise_if.noise_value !== pending_noise[0]) begin
          $display("%0t: noise_value mismatch, expected %h, actual %h",
                   $time, pending_noise[0], noise_if.noise_value);
          errors++;
        end
        void'(pending_noise.pop_front());
      end
    end
  end

  // -------------------------------------------------------------- sender

  // offer one coordinate word, push its prediction once accepted
  task automatic send_coord(logic signed [vnf_pkg::CoordWidth-1:0] xc,
                            logic signed [vnf_pkg::CoordWidth-1:0] yc);
    if ($urandom_range(99) < tx_idle_pct) begin
      coord_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    coord_if.valid   <= 1'b1;
    coord_if.x_coord <= xc;
    coord_if.y_coord <= yc;
    do @(posedge clk_i); while (!coord_if.ready);
    pending_noise.push_back(fbm_noise(xc, yc));
  endtask

  task automatic go_quiet();
    coord_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // half full range, plus small magnitudes and exact lattice points
  function automatic logic [vnf_pkg::CoordWidth-1:0] rand_coord();
    logic [vnf_pkg::CoordWidth-1:0] v;
    v = vnf_pkg::CoordWidth'($urandom());
    case ($urandom_range(5))
      0: v = {{7{v[23]}}, v[16:0]};
      1: v[15:0] = '0;
      2: v = {{12{v[23]}}, v[11:0]};
      default: ;
    endcase
    return v;
  endfunction

  // --------------------------------------------------------------- tests

  // extremes, zero, signs, integer points, fractions next to one
  task automatic test_directed();
    logic signed [vnf_pkg::CoordWidth-1:0] corner_vals [8];
    corner_vals = '{24'sh000000, 24'sh7fffff, 24'sh800000, 24'shffffff,
                    24'sh000001, 24'sh010000, 24'shff0000, 24'sh00ffff};
    foreach (corner_vals[i]) send_coord(corner_vals[i], corner_vals[(i + 3) % 8]);
    foreach (corner_vals[i]) send_coord(corner_vals[i], corner_vals[i]);
    send_coord(24'sh000000, 24'sh123456);
    send_coord(24'sh7fffff, 24'sh800000);
    send_coord(24'sh555555, 24'shaaaaaa);
    send_coord(24'shaaaaaa, 24'sh555555);
  endtask

  task automatic test_random(int count);
    repeat (count) send_coord(rand_coord(), rand_coord());
  endtask

  // receiver stalls long while words keep coming, so the input backs up
  task automatic test_backpressure();
    rx_hold_left = 300;
    repeat (60) send_coord(rand_coord(), rand_coord());
  endtask

  // sender waits until everything in flight has come out
  task automatic test_drain_pause();
    go_quiet();
    while (pending_noise.size() != 0) @(posedge clk_i);
    repeat (20) send_coord(rand_coord(), rand_coord());
  endtask

  initial begin
    clk_i            = 1'b0;
    rst_ni           = 1'b0;
    coord_if.valid   = 1'b0;
    coord_if.x_coord = '0;
    coord_if.y_coord = '0;
    rx_hold_left     = 0;
    errors           = 0;
    tx_idle_pct      = 13;
    rx_idle_pct      = 55;
    build_cos_weights();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random(500);
    test_drain_pause();
    tx_idle_pct = 55;
    rx_idle_pct = 13;
    test_random(450);
    test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random(450);
    go_quiet();

    // let the pipe empty, then a little slack for strays
    fork
      begin
        while (pending_noise.size() != 0) @(posedge clk_i);
      end
      begin
        repeat (5000) @(posedge clk_i);
      end
    join_any
    disable fork;
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0 && pending_noise.size() == 0) begin
      $display("fractal_value_noise_2d_top test passed");
    end else begin
      $display("fractal_value_noise_2d_top test failed");
    end
    $finish;
  end

endmodule
